>>> rtl/core/multi_server_queue_dispatcher_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the multi-server queue dispatcher
// Concurrent checks, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef MULTI_SERVER_QUEUE_DISPATCHER_MACROS_SVH
`define MULTI_SERVER_QUEUE_DISPATCHER_MACROS_SVH
`ifndef SYNTH
// condition must hold at every clock edge outside reset
`define MSQD_ASSERT(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("msqd: check failed");
// consequent must hold in the same cycle as the antecedent
`define MSQD_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("msqd: implication failed");
`else
`define MSQD_ASSERT(label, clk, rst, cond)
`define MSQD_ASSERT_IMP(label, clk, rst, ante, cons)
`endif
`endif

>>> rtl/core/msqd_pkg.sv
// ----------------------------------------------------------------------------
// msqd_pkg
// Shared constants, payload structs and cell types of the dispatcher.
// ----------------------------------------------------------------------------
`default_nettype none

package msqd_pkg;

  localparam int MAX_WINDOWS = 16;
  localparam int IDX_W = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
  localparam int CNT_W = ($clog2(MAX_WINDOWS + 1) > 5) ? $clog2(MAX_WINDOWS + 1) : 5;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_WINDOWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SERVICE    = 1'b1;
  localparam int CFG_DATA_W = 8;

  localparam logic [4:0] ACTIVE_WINDOWS_RESET = 5'd1;
  localparam logic [7:0] MAX_SERVICE_RESET    = 8'd60;

  typedef struct packed {
    logic [23:0] arrival_time;
    logic [7:0]  service_time;
  } msqd_in_t;

  typedef struct packed {
    logic [3:0]  window_index;
    logic [23:0] wait_time;
    logic [31:0] total_wait;
    logic [23:0] max_wait;
    logic [23:0] latest_finish;
    logic [15:0] served_by_window;
  } msqd_out_t;

  // per-server state held in one ring cell
  typedef struct packed {
    logic [23:0] free_at;
    logic [15:0] jobs;
  } srv_t;

  typedef struct packed {
    logic             clear;
    logic             step;
    logic [IDX_W-1:0] pos;
  } scan_ctrl_t;

  typedef struct packed {
    logic             found;
    logic [23:0]      best;
    logic [IDX_W-1:0] pick;
    logic [15:0]      jobs;
  } scan_res_t;

endpackage

`default_nettype wire

>>> rtl/core/msqd_cell.sv
// ----------------------------------------------------------------------------
// msqd_cell
// One server slot of the rotating ring: free-at time and served count.
// ----------------------------------------------------------------------------
`default_nettype none

module msqd_cell (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           shift,
  input  wire msqd_pkg::srv_t d,
  output msqd_pkg::srv_t      q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (shift) begin
      q <= d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/msqd_scan.sv
// ----------------------------------------------------------------------------
// msqd_scan
// Shared comparator: examines the ring head once per cycle while the scan
// steps, and tracks the first free server or else the earliest-free one.
// ----------------------------------------------------------------------------
`default_nettype none

module msqd_scan (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire msqd_pkg::scan_ctrl_t           ctrl,
  input  wire msqd_pkg::srv_t                 head,
  input  wire logic [23:0]                    arrival,
  input  wire logic [msqd_pkg::CNT_W-1:0]     count,
  output msqd_pkg::scan_res_t                 res
);

  logic in_range;

  assign in_range = msqd_pkg::CNT_W'(ctrl.pos) < count;

  // candidate fields need no reset, only the found flag does
  always_ff @(posedge clk) begin
    if (rst) begin
      res.found <= 1'b0;
    end else if (ctrl.clear) begin
      res.found <= 1'b0;
    end else if (ctrl.step && in_range && !res.found) begin
      if (head.free_at <= arrival) begin
        res.found <= 1'b1;
        res.pick  <= ctrl.pos;
        res.jobs  <= head.jobs;
      end else if (ctrl.pos == '0 || head.free_at < res.best) begin
        res.best <= head.free_at;
        res.pick <= ctrl.pos;
        res.jobs <= head.jobs;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/multi_server_queue_dispatcher.sv
// ----------------------------------------------------------------------------
// multi_server_queue_dispatcher
// Earliest-available-server list scheduling over a ring of server cells.
// ----------------------------------------------------------------------------
// Each request carries a job (arrival time, service time). The job goes to
// the lowest-index active server already free at arrival, or else to the
// earliest-free server (lowest index on ties), and one result request
// reports the server, the job's wait and the running statistics. Server
// state lives in a ring of MAX_WINDOWS cells that rotates one place per
// cycle while scanning, past a single shared comparator, so every job
// costs one full turn of the ring: a request is taken while idle, the scan
// passes all MAX_WINDOWS cells, then the update state writes the statistics
// once the output register is free. The chosen server's new state is
// written back as it passes the head during the next job's turn. A result
// waits in an output register, so a new job is taken while the previous
// result is still unread. The user must write configuration through
// cfg_we/cfg_index/cfg_data only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

`include "multi_server_queue_dispatcher_macros.svh"

module multi_server_queue_dispatcher (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire msqd_pkg::msqd_in_t                  in_data,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output msqd_pkg::msqd_out_t                      out_data,
  input  wire logic                                cfg_we,
  input  wire logic [msqd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [msqd_pkg::CFG_DATA_W-1:0]     cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_CALC = 3'b100
  } state_t;

  state_t state, state_next;

  // configuration registers
  logic [4:0] active_windows;
  logic [7:0] max_service;

  // job under work
  logic [23:0] arr_q;
  logic [7:0]  svc_q;

  // scan position, equals the number of ring rotations done in this turn
  logic [msqd_pkg::IDX_W-1:0] pos;
  logic                       last_pos;

  // deferred write-back of the previous job's server
  logic                       pend_valid;
  logic [msqd_pkg::IDX_W-1:0] pend_idx;
  msqd_pkg::srv_t             pend_srv;
  logic                       pend_hit;

  // running statistics
  logic [31:0] wait_sum;
  logic [23:0] wait_peak;
  logic [23:0] finish_peak;

  msqd_pkg::srv_t      ring [msqd_pkg::MAX_WINDOWS];
  msqd_pkg::srv_t      head_cur;
  msqd_pkg::scan_ctrl_t scan_ctrl;
  msqd_pkg::scan_res_t  scan_res;

  logic [msqd_pkg::CNT_W-1:0] aw_ext;
  logic [msqd_pkg::CNT_W-1:0] eff_count;

  logic        in_fire;
  logic        calc_go;
  logic        shift;
  logic [23:0] base;
  logic [24:0] fin_sum;
  logic [23:0] new_free;
  logic [15:0] new_jobs;
  logic [23:0] wait_now;
  logic [32:0] wsum_ext;
  logic [31:0] wsum_new;
  logic [23:0] wpeak_new;
  logic [23:0] fpeak_new;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      active_windows <= msqd_pkg::ACTIVE_WINDOWS_RESET;
      max_service    <= msqd_pkg::MAX_SERVICE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        msqd_pkg::CFG_ACTIVE_WINDOWS: active_windows <= cfg_data[4:0];
        msqd_pkg::CFG_MAX_SERVICE:    max_service    <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp the server count into one..MAX_WINDOWS
  assign aw_ext = msqd_pkg::CNT_W'(active_windows);
  always_comb begin
    if (aw_ext == '0) begin
      eff_count = msqd_pkg::CNT_W'(1);
    end else if (aw_ext > msqd_pkg::CNT_W'(msqd_pkg::MAX_WINDOWS)) begin
      eff_count = msqd_pkg::CNT_W'(msqd_pkg::MAX_WINDOWS);
    end else begin
      eff_count = aw_ext;
    end
  end

  // ------------------------------------------------------------------ FSM
  assign in_ready = (state == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign last_pos = (pos == msqd_pkg::IDX_W'(msqd_pkg::MAX_WINDOWS - 1));
  // leave the update cycle only when the output register can take the result
  assign calc_go  = (state == ST_CALC) && (!out_valid || out_ready);
  assign shift    = (state == ST_SCAN);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_fire) state_next = ST_SCAN;
      ST_SCAN: if (last_pos) state_next = ST_CALC;
      ST_CALC: if (calc_go) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pos   <= '0;
    end else begin
      state <= state_next;
      if (shift) begin
        pos <= last_pos ? '0 : pos + 1'b1;
      end
    end
  end

  // latch the job, clip the service time on the way in
  always_ff @(posedge clk) begin
    if (in_fire) begin
      arr_q <= in_data.arrival_time;
      svc_q <= (in_data.service_time > max_service) ? max_service
                                                    : in_data.service_time;
    end
  end

  // ----------------------------------------------------------------- ring
  // Head sees the pending write-back when its server comes around, and the
  // updated value rotates on toward the tail.
  assign pend_hit = pend_valid && (pend_idx == pos);
  assign head_cur = pend_hit ? pend_srv : ring[0];

  for (genvar i = 0; i < msqd_pkg::MAX_WINDOWS; i++) begin : g_cell
    msqd_pkg::srv_t cell_d;
    if (i == msqd_pkg::MAX_WINDOWS - 1) begin : g_tail
      assign cell_d = head_cur;
    end else begin : g_mid
      assign cell_d = ring[i+1];
    end
    msqd_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (shift),
      .d     (cell_d),
      .q     (ring[i])
    );
  end

  assign scan_ctrl.clear = in_fire;
  assign scan_ctrl.step  = shift;
  assign scan_ctrl.pos   = pos;

  msqd_scan u_scan (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (scan_ctrl),
    .head    (head_cur),
    .arrival (arr_q),
    .count   (eff_count),
    .res     (scan_res)
  );

  // ------------------------------------------------------------- update
  assign base     = scan_res.found ? arr_q : scan_res.best;
  assign fin_sum  = {1'b0, base} + {17'd0, svc_q};
  assign new_free = fin_sum[24] ? 24'hFF_FFFF : fin_sum[23:0];
  assign new_jobs = (scan_res.jobs == 16'hFFFF) ? scan_res.jobs : scan_res.jobs + 16'd1;
  assign wait_now = scan_res.found ? 24'd0 : scan_res.best - arr_q;
  assign wsum_ext = {1'b0, wait_sum} + {9'd0, wait_now};
  assign wsum_new = wsum_ext[32] ? 32'hFFFF_FFFF : wsum_ext[31:0];
  assign wpeak_new = (wait_now > wait_peak) ? wait_now : wait_peak;
  assign fpeak_new = (new_free > finish_peak) ? new_free : finish_peak;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid  <= 1'b0;
      wait_sum    <= '0;
      wait_peak   <= '0;
      finish_peak <= '0;
    end else if (calc_go) begin
      pend_valid  <= 1'b1;
      wait_sum    <= wsum_new;
      wait_peak   <= wpeak_new;
      finish_peak <= fpeak_new;
    end else if (shift && pend_hit) begin
      // drop the write-back once it is in the ring
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (calc_go) begin
      pend_idx         <= scan_res.pick;
      pend_srv.free_at <= new_free;
      pend_srv.jobs    <= new_jobs;
    end
  end

  // --------------------------------------------------------------- output
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (calc_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (calc_go) begin
      out_data.window_index     <= 4'(scan_res.pick);
      out_data.wait_time        <= wait_now;
      out_data.total_wait       <= wsum_new;
      out_data.max_wait         <= wpeak_new;
      out_data.latest_finish    <= fpeak_new;
      out_data.served_by_window <= new_jobs;
    end
  end

  // ----------------------------------------------------------- assertions
  // ring is back in order whenever no scan is running
  `MSQD_ASSERT_IMP(a_ring_aligned, clk, rst, state != ST_SCAN, pos == '0)
  // chosen server lies among the active ones
  `MSQD_ASSERT_IMP(a_pick_active, clk, rst, state == ST_CALC, msqd_pkg::CNT_W'(scan_res.pick) < eff_count)
  // with no free server the earliest one frees up after arrival
  `MSQD_ASSERT_IMP(a_busy_wait, clk, rst, state == ST_CALC && !scan_res.found, scan_res.best > arr_q)
  // a result only appears from the update cycle
  `MSQD_ASSERT_IMP(a_out_src, clk, rst, $rose(out_valid), $past(state) == ST_CALC)

endmodule

`default_nettype wire

>>> sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the multi-server queue dispatcher
// Feeds job requests through the valid/ready input, predicts the server
// choice, wait and running statistics of every job, and checks each result
// request field by field. Configuration changes between phases, only while
// the dispatcher is idle; both sides idle at random but in one steady phase.
// ----------------------------------------------------------------------------
module tb;

  // Pause before a configuration write, with margin; the last write-back
  // stays pending until the next job's turn brings its server around.
  localparam int SETTLE_CYCLES  = 40;
  // Cycles without any accepted request before the run is declared hung.
  localparam int STALL_LIMIT    = 2000;
  localparam int RANDOM_PHASES  = 6;
  localparam int JOBS_PER_PHASE = 75;
  // Enough maximal waits to push the 32-bit wait sum into saturation.
  localparam int SATURATE_JOBS  = 260;
  localparam int IDLE_PERCENT   = 8;

  logic                            clk;
  logic                            rst       = 1'b1;
  logic                            in_valid  = 1'b0;
  logic                            in_ready;
  msqd_pkg::msqd_in_t              in_data   = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  msqd_pkg::msqd_out_t             out_data;
  logic                            cfg_we    = 1'b0;
  logic [msqd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [msqd_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  multi_server_queue_dispatcher i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Scheduler state as the bench sees it: per-server free-at time and job
  // count, plus the running statistics and the active configuration.
  logic [23:0] srv_free_at [msqd_pkg::MAX_WINDOWS];
  logic [15:0] srv_jobs    [msqd_pkg::MAX_WINDOWS];
  logic [31:0] wait_total;
  logic [23:0] wait_high;
  logic [23:0] finish_high;
  logic [4:0]  servers_cfg;
  logic [7:0]  clip_cfg;

  msqd_pkg::msqd_in_t  job_pending [$];   // job requests not yet presented
  msqd_pkg::msqd_out_t result_due  [$];   // predicted results, oldest first

  bit job_accepted;             // input request taken at the last rising edge
  bit steady_flow;              // suppress random idling on both sides
  int mismatch_count;
  int stall_cycles;
  int timeline;                 // arrival clock of the generated jobs

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Place one job: lowest-index free server with no wait, else the
  // earliest-free server (lowest index on ties), then update statistics.
  function automatic msqd_pkg::msqd_out_t assign_job(msqd_pkg::msqd_in_t job);
    msqd_pkg::msqd_out_t res;
    int          n;
    int          pick;
    bit          found;
    logic [23:0] best;
    logic [7:0]  svc;
    logic [23:0] wait_len;
    logic [24:0] end_sum;
    logic [32:0] wait_sum_next;
    n = servers_cfg;
    if (n < 1) n = 1;                      // zero servers acts as one
    if (n > msqd_pkg::MAX_WINDOWS) n = msqd_pkg::MAX_WINDOWS;  // clamp oversized counts
    svc = (job.service_time > clip_cfg) ? clip_cfg : job.service_time;
    found = 1'b0;
    pick = 0;
    best = '0;
    wait_len = '0;
    for (int i = 0; i < n; i++) begin
      if (!found) begin
        if (srv_free_at[i] <= job.arrival_time) begin
          pick = i;
          found = 1'b1;
        end else if (i == 0 || srv_free_at[i] < best) begin
          best = srv_free_at[i];
          pick = i;
        end
      end
    end
    if (found) begin
      end_sum = {1'b0, job.arrival_time} + svc;
    end else begin
      wait_len = srv_free_at[pick] - job.arrival_time;
      end_sum = {1'b0, srv_free_at[pick]} + svc;
      if (wait_len > wait_high) wait_high = wait_len;
      wait_sum_next = {1'b0, wait_total} + wait_len;
      wait_total = wait_sum_next[32] ? '1 : wait_sum_next[31:0];
    end
    // saturate the finish time at the top of the 24-bit range
    srv_free_at[pick] = end_sum[24] ? '1 : end_sum[23:0];
    if (srv_jobs[pick] != '1) srv_jobs[pick] = srv_jobs[pick] + 16'd1;
    if (srv_free_at[pick] > finish_high) finish_high = srv_free_at[pick];
    res.window_index     = 4'(pick);
    res.wait_time        = wait_len;
    res.total_wait       = wait_total;
    res.max_wait         = wait_high;
    res.latest_finish    = finish_high;
    res.served_by_window = srv_jobs[pick];
    return res;
  endfunction

  task automatic check_field(string label, logic [31:0] want_v, logic [31:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want_v, got_v);
      mismatch_count++;
    end
  endtask

  task automatic queue_job(int arrival, int service);
    msqd_pkg::msqd_in_t job;
    job.arrival_time = 24'(arrival);
    job.service_time = 8'(service);
    job_pending.push_back(job);
  endtask

  // Hold until every queued job is accepted and every result has arrived,
  // then pause for margin before going on.
  task automatic wait_drained();
    while (job_pending.size() != 0 || in_valid || result_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(logic [msqd_pkg::CFG_IDX_W-1:0] idx,
                           logic [msqd_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx == msqd_pkg::CFG_ACTIVE_WINDOWS) servers_cfg = val[4:0];
    else clip_cfg = val;
  endtask

  // Drain first: registers change only while the dispatcher is idle.
  task automatic set_config(int servers, int clip);
    wait_drained();
    write_cfg(msqd_pkg::CFG_ACTIVE_WINDOWS, msqd_pkg::CFG_DATA_W'(servers));
    write_cfg(msqd_pkg::CFG_MAX_SERVICE, msqd_pkg::CFG_DATA_W'(clip));
  endtask

  // Driver: present the next pending job once the current request is taken,
  // idling at random between requests.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || job_accepted) begin
      if (job_pending.size() != 0 &&
          (steady_flow || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
        in_valid <= 1'b1;
        in_data  <= job_pending.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Stall the result side at random.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end
  end

  // Monitor: check results against the oldest prediction, predict each
  // accepted job, and watch for a hung handshake.
  always @(posedge clk) begin
    msqd_pkg::msqd_out_t want;
    job_accepted = 1'b0;
    if (!rst) begin
      // check the result side first so a new prediction never pairs with it
      if (out_valid && out_ready) begin
        if (result_due.size() == 0) begin
          $display("%0t: result request with nothing expected, actual %0h",
                   $time, out_data);
          mismatch_count++;
        end else begin
          want = result_due.pop_front();
          check_field("window_index", 32'(want.window_index), 32'(out_data.window_index));
          check_field("wait_time", 32'(want.wait_time), 32'(out_data.wait_time));
          check_field("total_wait", want.total_wait, out_data.total_wait);
          check_field("max_wait", 32'(want.max_wait), 32'(out_data.max_wait));
          check_field("latest_finish", 32'(want.latest_finish),
                      32'(out_data.latest_finish));
          check_field("served_by_window", 32'(want.served_by_window),
                      32'(out_data.served_by_window));
        end
      end
      if (in_valid && in_ready) begin
        job_accepted = 1'b1;
        result_due.push_back(assign_job(in_data));
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("%0t: no request accepted for %0d cycles", $time, STALL_LIMIT);
          $display("Simulation FAILED");
          $finish;
        end
      end
    end
  end

  initial begin
    int r;
    int servers;
    int start;
    int back;
    int slack;
    for (int i = 0; i < msqd_pkg::MAX_WINDOWS; i++) begin
      srv_free_at[i] = '0;
      srv_jobs[i]    = '0;
    end
    wait_total     = '0;
    wait_high      = '0;
    finish_high    = '0;
    servers_cfg    = msqd_pkg::ACTIVE_WINDOWS_RESET;
    clip_cfg       = msqd_pkg::MAX_SERVICE_RESET;
    mismatch_count = 0;
    stall_cycles   = 0;
    steady_flow    = 1'b0;
    timeline       = 0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: reset configuration, one server, clip at the reset limit.
    queue_job(0, 0);
    queue_job(0, 255);      // clipped to the reset limit
    queue_job(10, 61);      // waits behind the first server
    queue_job(10, 60);

    // Zero server count acts as one; zero clip limit drops every service.
    set_config(0, 0);
    queue_job(20, 200);
    queue_job(180, 255);    // free exactly at arrival

    // Oversized server count clamps to all servers: fill them, then tie.
    set_config(31, 255);
    for (int i = 0; i < msqd_pkg::MAX_WINDOWS; i++) queue_job(130, 255);
    queue_job(131, 255);    // all busy; servers 1 to 15 tie on the earliest free time

    // Earliest-free pick, then an arrival that goes backward.
    set_config(msqd_pkg::MAX_WINDOWS, 1);
    queue_job(140, 5);
    queue_job(50, 1);

    // Shrink the pool: upper servers keep their state and finish times.
    set_config(2, 1);
    queue_job(700, 3);
    timeline = 700;

    // Random phases: each starts in a higher band of the arrival range so
    // the high arrival bits toggle, with bursts that build queues, gaps that
    // free the servers and a few backward arrivals as noise.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin
          servers = msqd_pkg::MAX_WINDOWS;
          set_config(servers, 255);
        end
        1: begin
          servers = 1;
          set_config(servers, 1);
        end
        default: begin
          r = $urandom_range(0, 9);
          if (r == 0) servers = $urandom_range(17, 31);
          else if (r == 1) servers = 0;
          else servers = $urandom_range(1, msqd_pkg::MAX_WINDOWS);
          set_config(servers, $urandom_range(1, 255));
        end
      endcase
      if (servers < 1) servers = 1;
      if (servers > msqd_pkg::MAX_WINDOWS) servers = msqd_pkg::MAX_WINDOWS;
      steady_flow = (p == 2);
      slack = 120 / servers;
      start = p * 24'h200000 + $urandom_range(0, 24'h1FFFFF);
      if (start > timeline) timeline = start;
      for (int k = 0; k < JOBS_PER_PHASE; k++) begin
        r = $urandom_range(0, 99);
        if (r < 5) begin
          back = $urandom_range(0, 300);
          if (back > timeline) back = timeline;
          queue_job(timeline - back, $urandom_range(0, 255));
        end else begin
          if (r < 8) timeline += $urandom_range(0, 5000);
          else timeline += $urandom_range(0, slack);
          queue_job(timeline, $urandom_range(0, 255));
        end
      end
    end
    wait_drained();
    steady_flow = 1'b0;

    // Top of the range: saturate the finish time, then drive maximal waits
    // with early arrivals until the wait sum saturates.
    set_config(1, 255);
    queue_job(24'hFFFFF0, 255);
    queue_job(24'hFFFFFF, 0);
    for (int k = 0; k < SATURATE_JOBS; k++)
      queue_job($urandom_range(0, 255), $urandom_range(0, 255));
    wait_drained();

    mismatch_count += result_due.size();
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
